/* hw/rtl/symbol_floor_lookup_assert.svh */
// symbol_floor_lookup_assert.svh: assertion macros shared by the RTL.
// Expects signals named clock and reset in the scope of each use.
`ifndef SYMBOL_FLOOR_LOOKUP_ASSERT_SVH
`define SYMBOL_FLOOR_LOOKUP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SFL_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SFL_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/sfl_pkg.sv */
// sfl_pkg.sv: types, constants and helpers for the symbol floor lookup.
// No dependencies; used by every other RTL file of the block but symbol_floor_lookup_assert.svh.
package sfl_pkg;

   // Table size default and symbol_count width
   localparam int MAX_SYMBOLS_DEFAULT = 1024;
   localparam int COUNT_W             = 11;

   // ELF symbol types that a lookup accepts
   localparam logic [3:0] KIND_NOTYPE = 4'd0;
   localparam logic [3:0] KIND_OBJECT = 4'd1;
   localparam logic [3:0] KIND_FUNC   = 4'd2;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_LOOKUP = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // One input beat
   typedef struct packed {
      opcode_type  opcode;
      logic [9:0]  entry_index;
      logic [63:0] entry_start;
      logic [31:0] entry_name_offset;
      logic [3:0]  entry_kind;
      logic        entry_dollar;
      logic [63:0] query_address;
   } req_type;

   // One result beat
   typedef struct packed {
      logic        found;
      logic [9:0]  best_index;
      logic [31:0] best_name_offset;
      logic [63:0] distance;
   } rsp_type;

   // One table slot
   typedef struct packed {
      logic [63:0] start;
      logic [31:0] name_offset;
      logic [3:0]  kind;
      logic        dollar;
   } entry_type;

   // Named, of an accepted type, and not a '$' name
   function automatic logic qualifies(entry_type e);
      logic kind_ok;
      case (e.kind)
         KIND_NOTYPE, KIND_OBJECT, KIND_FUNC: kind_ok = 1'b1;
         default:                             kind_ok = 1'b0;
      endcase
      return (e.name_offset != 32'd0) && kind_ok && !e.dollar;
   endfunction

endpackage

/* hw/rtl/sfl_req_if.sv */
// sfl_req_if.sv: valid/ready channel carrying request beats.
// Depends on sfl_pkg.
interface sfl_req_if;
   logic             valid;
   logic             ready;
   sfl_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/sfl_rsp_if.sv */
// sfl_rsp_if.sv: valid/ready channel carrying result beats.
// Depends on sfl_pkg.
interface sfl_rsp_if;
   logic             valid;
   logic             ready;
   sfl_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/sfl_table.sv */
// sfl_table.sv: symbol table memory, one write port, one registered read port.
// Depends on sfl_pkg.
module sfl_table #(
   parameter int DEPTH  = sfl_pkg::MAX_SYMBOLS_DEFAULT,
   parameter int ADDR_W = 10
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  sfl_pkg::entry_type wr_data,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output sfl_pkg::entry_type rd_data
);

   sfl_pkg::entry_type mem [DEPTH];
   sfl_pkg::entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/sfl_scan.sv */
// sfl_scan.sv: request sequencer, table scan and result register.
// Depends on sfl_pkg, sfl_req_if, sfl_rsp_if and symbol_floor_lookup_assert.svh.
`include "symbol_floor_lookup_assert.svh"

module sfl_scan #(
   parameter int MAX_SYMBOLS = sfl_pkg::MAX_SYMBOLS_DEFAULT,
   parameter int IDX_W       = 10,
   parameter int CNT_W       = 11
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [sfl_pkg::COUNT_W-1:0] symbol_count,
   sfl_req_if.sink                     req_bus,
   sfl_rsp_if.source                   rsp_bus,
   output logic                        wr_en,
   output logic [IDX_W-1:0]            wr_addr,
   output sfl_pkg::entry_type          wr_data,
   output logic                        rd_en,
   output logic [IDX_W-1:0]            rd_addr,
   input  sfl_pkg::entry_type          rd_data
);

   sfl_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   limit_ff, limit_in;
   logic [63:0]        query_ff, query_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               have_ff, have_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [63:0]        best_start_ff, best_start_in;
   logic [31:0]        best_name_ff, best_name_in;
   logic               rsp_valid_ff, rsp_valid_in;
   sfl_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic        req_fire;
   logic        is_lookup;
   logic        scan_done;
   logic        rsp_load;
   logic        take;
   logic [31:0] wr_idx_wide;
   logic [31:0] best_idx_wide;

   assign req_fire  = req_bus.valid && req_bus.ready;
   assign is_lookup = (req_bus.payload.opcode == sfl_pkg::OP_LOOKUP);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sfl_pkg::ST_IDLE: begin
            if (req_fire && is_lookup) state_in = sfl_pkg::ST_SCAN;
         end
         sfl_pkg::ST_SCAN: begin
            if (scan_done) state_in = sfl_pkg::ST_FINISH;
         end
         sfl_pkg::ST_FINISH: begin
            if (rsp_load) state_in = sfl_pkg::ST_IDLE;
         end
         default: state_in = sfl_pkg::ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_bus.ready = 1'b0;
      rd_en         = 1'b0;
      scan_done     = 1'b0;
      rsp_load      = 1'b0;
      unique case (state_ff)
         sfl_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
         end
         sfl_pkg::ST_SCAN: begin
            rd_en     = (cnt_ff < limit_ff);
            scan_done = !(cnt_ff < limit_ff) && !rd_vld_ff;
         end
         sfl_pkg::ST_FINISH: begin
            rsp_load = !rsp_valid_ff || rsp_bus.ready;
         end
         default: ;
      endcase
   end

   // Table write from a write beat; slots past the table are dropped
   assign wr_idx_wide = 32'(req_bus.payload.entry_index);
   assign wr_en   = req_fire && !is_lookup && (wr_idx_wide < 32'(MAX_SYMBOLS));
   assign wr_addr = wr_idx_wide[IDX_W-1:0];
   assign wr_data = '{start:       req_bus.payload.entry_start,
                      name_offset: req_bus.payload.entry_name_offset,
                      kind:        req_bus.payload.entry_kind,
                      dollar:      req_bus.payload.entry_dollar};

   assign rd_addr = cnt_ff[IDX_W-1:0];

   // Candidate check on the slot read last cycle
   assign take = rd_vld_ff && sfl_pkg::qualifies(rd_data)
                 && (rd_data.start <= query_ff)
                 && (!have_ff || (rd_data.start > best_start_ff));

   // Scan datapath
   always_comb begin
      cnt_in        = cnt_ff;
      limit_in      = limit_ff;
      query_in      = query_ff;
      rd_vld_in     = rd_en;
      rd_idx_in     = rd_addr;
      have_in       = have_ff;
      best_idx_in   = best_idx_ff;
      best_start_in = best_start_ff;
      best_name_in  = best_name_ff;
      if (req_fire && is_lookup) begin
         cnt_in   = '0;
         query_in = req_bus.payload.query_address;
         have_in  = 1'b0;
         if (32'(symbol_count) > 32'(MAX_SYMBOLS)) begin
            limit_in = CNT_W'(MAX_SYMBOLS);
         end else begin
            limit_in = CNT_W'(symbol_count);
         end
      end
      if (rd_en) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (take) begin
         have_in       = 1'b1;
         best_idx_in   = rd_idx_ff;
         best_start_in = rd_data.start;
         best_name_in  = rd_data.name_offset;
      end
   end

   // Result register
   assign best_idx_wide = 32'(best_idx_ff);
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         if (have_ff) begin
            rsp_data_in = '{found:            1'b1,
                            best_index:       best_idx_wide[9:0],
                            best_name_offset: best_name_ff,
                            distance:         query_ff - best_start_ff};
         end else begin
            rsp_data_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sfl_pkg::ST_IDLE;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         have_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         have_ff      <= have_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      limit_ff      <= limit_in;
      query_ff      <= query_in;
      rd_idx_ff     <= rd_idx_in;
      best_idx_ff   <= best_idx_in;
      best_start_ff <= best_start_in;
      best_name_ff  <= best_name_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_data_ff;

   // Checks
   `SFL_ASSERT_IMP(a_best_below_query, have_ff, best_start_ff <= query_ff, "best start above query")
   `SFL_ASSERT_IMP(a_load_into_free, rsp_load, !rsp_valid_ff || rsp_bus.ready, "result overwritten")
   `SFL_ASSERT_NXT(a_load_to_idle, rsp_load, state_ff == sfl_pkg::ST_IDLE && rsp_valid_ff, "load did not finish")
   `SFL_ASSERT_IMP(a_read_in_scan, rd_vld_ff, state_ff == sfl_pkg::ST_SCAN, "read data outside scan")

endmodule

/* hw/rtl/symbol_floor_lookup.sv */
// symbol_floor_lookup.sv: top level of the symbol floor lookup block.
// Depends on sfl_pkg, sfl_req_if, sfl_rsp_if, sfl_table and sfl_scan.
//
//   channel  direction  beat                                   handshake
//   req_bus  in         write slot or look up an address       valid/ready
//   rsp_bus  out        found, slot, name offset, distance     valid/ready
//   csr_*    in         symbol_count                           write enable only
//
// A write beat writes its slot and leaves the block idle. With N = min(symbol_count,
// MAX_SYMBOLS), a lookup makes N table reads, one per slot, then checks the last read,
// sees the scan end and loads the result register. The load returns the block to idle,
// where it takes the next beat.
// A lookup waits in its final cycle while the result register still holds an untaken beat.
// Reset is synchronous; the table is not cleared, symbol_count resets to zero.
module symbol_floor_lookup #(
   parameter int MAX_SYMBOLS = sfl_pkg::MAX_SYMBOLS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   sfl_req_if.sink                     req_bus,
   sfl_rsp_if.source                   rsp_bus,
   input  logic                        csr_we,
   input  logic [sfl_pkg::COUNT_W-1:0] csr_wdata
);

   localparam int IDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
   localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);

   logic [sfl_pkg::COUNT_W-1:0] symbol_count_ff, symbol_count_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   sfl_pkg::entry_type wr_data;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   sfl_pkg::entry_type rd_data;

   // symbol_count register
   always_comb begin
      symbol_count_in = symbol_count_ff;
      if (csr_we) symbol_count_in = csr_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_count_ff <= '0;
      end else begin
         symbol_count_ff <= symbol_count_in;
      end
   end

   sfl_table #(
      .DEPTH  (MAX_SYMBOLS),
      .ADDR_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sfl_scan #(
      .MAX_SYMBOLS (MAX_SYMBOLS),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .symbol_count (symbol_count_ff),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data)
   );

endmodule

/* tb/tb_symbol_floor_lookup.sv */
`timescale 1ns / 1ps
// tb_symbol_floor_lookup.sv: self-checking testbench for symbol_floor_lookup.
// Drives write and lookup beats, predicts each floor result and compares it field by field.
// Depends on sfl_pkg, sfl_req_if, sfl_rsp_if and the symbol_floor_lookup RTL.
module tb_symbol_floor_lookup;

   localparam int          CLOCK_HALF    = 5;
   localparam int          RESET_CYCLES  = 12;
   localparam int          MAX_SLOTS     = sfl_pkg::MAX_SYMBOLS_DEFAULT;
   localparam int          SETTLE_CYCLES = 10;
   localparam int          TAIL_CYCLES   = 20;
   localparam int          QUIET_LIMIT   = 8000;
   localparam logic [63:0] DIRECTED_BASE = 64'h8000_0000_0000_1000;
   // ELF types a lookup must skip
   localparam logic [3:0]  KIND_SECTION  = 4'd3;
   localparam logic [3:0]  KIND_TOP      = 4'hF;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Testbench-owned drive values, known from time zero
   logic                        req_valid   = 1'b0;
   sfl_pkg::req_type            req_payload = '0;
   logic                        rsp_ready   = 1'b0;
   logic                        csr_we      = 1'b0;
   logic [sfl_pkg::COUNT_W-1:0] csr_wdata   = '0;

   sfl_req_if req_bus();
   sfl_rsp_if rsp_bus();

   assign req_bus.valid   = req_valid;
   assign req_bus.payload = req_payload;
   assign rsp_bus.ready   = rsp_ready;

   symbol_floor_lookup DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // Stimulus side
   sfl_pkg::req_type request_backlog[$];
   int               queued_beats   = 0;
   bit               idle_enable    = 1'b1;
   int               req_hold       = 0;
   int               rsp_hold       = 0;
   bit               slot_loaded[MAX_SLOTS];
   bit [63:0]        planned_start[MAX_SLOTS];
   logic [63:0]      start_base;

   // Prediction side
   sfl_pkg::entry_type symbol_shadow[MAX_SLOTS];
   logic [10:0]        scan_count     = '0;
   sfl_pkg::rsp_type   expected_floors[$];
   int                 accepted_beats = 0;
   bit                 req_beat_taken = 1'b0;
   int                 fault_count    = 0;
   int                 quiet_cycles   = 0;

   // Floor search over the shadow table: lowest slot wins on equal starts
   function automatic sfl_pkg::rsp_type resolve_floor(logic [63:0] query);
      sfl_pkg::rsp_type res;
      bit               hit;
      logic [63:0]      best_start;
      int               reach;
      res        = '0;
      hit        = 1'b0;
      best_start = '0;
      reach      = (scan_count > MAX_SLOTS) ? MAX_SLOTS : int'(scan_count);
      for (int i = 0; i < reach; i++) begin
         if (symbol_shadow[i].name_offset != 32'd0 &&
             symbol_shadow[i].kind inside {sfl_pkg::KIND_NOTYPE, sfl_pkg::KIND_OBJECT,
                                           sfl_pkg::KIND_FUNC} &&
             !symbol_shadow[i].dollar &&
             symbol_shadow[i].start <= query &&
             (!hit || symbol_shadow[i].start > best_start)) begin
            hit                  = 1'b1;
            best_start           = symbol_shadow[i].start;
            res.best_index       = 10'(i);
            res.best_name_offset = symbol_shadow[i].name_offset;
         end
      end
      if (hit) begin
         res.found    = 1'b1;
         res.distance = query - best_start;
      end
      return res;
   endfunction

   task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t rsp %s mismatch: expected %h actual %h", $time, field, want, got);
         fault_count++;
      end
   endtask

   task automatic queue_write(int slot, logic [63:0] start, logic [31:0] name,
                              logic [3:0] kind, logic dollar);
      sfl_pkg::req_type beat;
      beat.opcode            = sfl_pkg::OP_WRITE;
      beat.entry_index       = 10'(slot);
      beat.entry_start       = start;
      beat.entry_name_offset = name;
      beat.entry_kind        = kind;
      beat.entry_dollar      = dollar;
      beat.query_address     = {$urandom, $urandom};
      request_backlog.push_back(beat);
      queued_beats++;
      slot_loaded[slot]   = 1'b1;
      planned_start[slot] = start;
   endtask

   // Lookup beat; the entry fields are don't-care and carry noise
   task automatic queue_lookup(logic [63:0] query);
      sfl_pkg::req_type beat;
      beat.opcode            = sfl_pkg::OP_LOOKUP;
      beat.entry_index       = 10'($urandom);
      beat.entry_start       = {$urandom, $urandom};
      beat.entry_name_offset = $urandom;
      beat.entry_kind        = 4'($urandom);
      beat.entry_dollar      = 1'($urandom);
      beat.query_address     = query;
      request_backlog.push_back(beat);
      queued_beats++;
   endtask

   // Mostly clustered starts so that lookups land between neighbors
   task automatic queue_random_write(int slot);
      logic [63:0] start;
      logic [31:0] name;
      logic [3:0]  kind;
      case ($urandom_range(0, 9))
         0:       start = {$urandom, $urandom};
         1:       start = planned_start[$urandom_range(0, MAX_SLOTS - 1)];
         default: start = start_base + 64'($urandom_range(0, 4095));
      endcase
      if ($urandom_range(0, 7) == 0)
         name = '0;
      else if ($urandom_range(0, 5) == 0)
         name = '1;
      else
         name = $urandom;
      kind = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(3, 15)) : 4'($urandom_range(0, 2));
      queue_write(slot, start, name, kind, ($urandom_range(0, 6) == 0));
   endtask

   // Queries near a stored start, plus the address extremes and noise
   function automatic logic [63:0] pick_query(int span);
      int reach;
      reach = (span > MAX_SLOTS) ? MAX_SLOTS : span;
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return {$urandom, $urandom};
         default: begin
            if (reach == 0)
               return {$urandom, $urandom};
            return planned_start[$urandom_range(0, reach - 1)]
                   + 64'($urandom_range(0, 16)) - 64'd4;
         end
      endcase
   endfunction

   task automatic wait_drained();
      while (accepted_beats != queued_beats || expected_floors.size() != 0)
         @(negedge clock);
      // a trailing write beat may still be in the block
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic load_count(logic [10:0] value);
      wait_drained();
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // Request driver: one beat held until taken, random gaps between beats
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_beat_taken) begin
         if (req_hold > 0) begin
            req_hold  = req_hold - 1;
            req_valid <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 7) == 0) begin
            req_hold  = $urandom_range(0, 13);
            req_valid <= 1'b0;
         end else if (request_backlog.size() > 0) begin
            req_payload <= request_backlog.pop_front();
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result sink: ready drops in random bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold  = rsp_hold - 1;
         rsp_ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         rsp_hold  = $urandom_range(0, 13);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: checks result beats, feeds the predictor, runs the watchdog
   always @(posedge clock) begin : monitor
      sfl_pkg::rsp_type got;
      sfl_pkg::rsp_type want;
      sfl_pkg::req_type beat;
      bit               rsp_taken;
      if (reset) begin
         req_beat_taken = 1'b0;
      end else begin
         rsp_taken = rsp_bus.valid && rsp_ready;
         if (rsp_taken) begin
            got = rsp_bus.payload;
            if (expected_floors.size() == 0) begin
               $display("%0t unexpected rsp beat: expected none actual %h", $time, got);
               fault_count++;
            end else begin
               want = expected_floors.pop_front();
               check_field("found", 64'(want.found), 64'(got.found));
               check_field("best_index", 64'(want.best_index), 64'(got.best_index));
               check_field("best_name_offset", 64'(want.best_name_offset),
                           64'(got.best_name_offset));
               check_field("distance", want.distance, got.distance);
            end
         end

         req_beat_taken = req_valid && req_bus.ready;
         if (req_beat_taken) begin
            beat = req_payload;
            accepted_beats++;
            if (beat.opcode == sfl_pkg::OP_WRITE) begin
               symbol_shadow[beat.entry_index].start       = beat.entry_start;
               symbol_shadow[beat.entry_index].name_offset = beat.entry_name_offset;
               symbol_shadow[beat.entry_index].kind        = beat.entry_kind;
               symbol_shadow[beat.entry_index].dollar      = beat.entry_dollar;
            end else begin
               expected_floors.push_back(resolve_floor(beat.query_address));
            end
         end

         if (csr_we)
            scan_count = csr_wdata;

         if (rsp_taken || req_beat_taken || csr_we)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("symbol_floor_lookup verification failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int span;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty scan right after reset
      queue_lookup('0);
      queue_lookup('1);

      // Directed table: equal starts, unnamed, bad types, dollar name, address extremes
      queue_write(0, DIRECTED_BASE + 64'd100, 32'd1, sfl_pkg::KIND_NOTYPE, 1'b0);
      queue_write(1, DIRECTED_BASE + 64'd100, '1, sfl_pkg::KIND_OBJECT, 1'b0);
      queue_write(2, DIRECTED_BASE + 64'd50, '0, sfl_pkg::KIND_FUNC, 1'b0);
      queue_write(3, DIRECTED_BASE + 64'd80, 32'd5, KIND_SECTION, 1'b0);
      queue_write(4, DIRECTED_BASE + 64'd90, 32'd6, sfl_pkg::KIND_FUNC, 1'b1);
      queue_write(5, '0, 32'd7, sfl_pkg::KIND_FUNC, 1'b0);
      queue_write(6, '1, 32'd9, sfl_pkg::KIND_OBJECT, 1'b0);
      queue_write(7, DIRECTED_BASE + 64'd70, 32'd3, sfl_pkg::KIND_FUNC, 1'b0);
      queue_write(MAX_SLOTS - 1, DIRECTED_BASE + 64'd10, 32'd11, KIND_TOP, 1'b0);
      load_count(11'd8);
      queue_lookup('0);
      queue_lookup(DIRECTED_BASE + 64'd99);
      queue_lookup(DIRECTED_BASE + 64'd100);
      queue_lookup(DIRECTED_BASE + 64'd200);
      queue_lookup(DIRECTED_BASE + 64'd85);
      queue_lookup(DIRECTED_BASE - 64'd1);
      queue_lookup('1);

      // Random phases over small tables, every scanned slot loaded first
      for (int phase = 0; phase < 13; phase++) begin
         if (phase == 0)
            span = 1;
         else if (phase == 1)
            span = 0;
         else
            span = $urandom_range(2, 48);
         load_count(11'(span));
         idle_enable = (phase % 4 != 3);
         start_base  = {$urandom, $urandom};
         for (int s = 0; s < span; s++)
            if (!slot_loaded[s])
               queue_random_write(s);
         for (int n = 0; n < 32; n++) begin
            if ($urandom_range(0, 99) < 55)
               queue_lookup(pick_query(span));
            else if (span > 0 && $urandom_range(0, 9) < 7)
               queue_random_write($urandom_range(0, span - 1));
            else
               queue_random_write($urandom_range(0, MAX_SLOTS - 1));
         end
      end

      // Last stretch at full rate, no idling on either side
      idle_enable = 1'b1;
      load_count(11'($urandom_range(1, 48)));
      idle_enable = 1'b0;
      for (int n = 0; n < 100; n++) begin
         if ($urandom_range(0, 1) == 0)
            queue_lookup(pick_query(int'(scan_count)));
         else
            queue_random_write($urandom_range(0, MAX_SLOTS - 1));
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fault_count == 0)
         $display("symbol_floor_lookup verification clean");
      else
         $display("symbol_floor_lookup verification failed");
      $finish;
   end

endmodule
